@@ rtl/core/bvfi_pkg.sv @@
// shared types, codes and constants of the velocity and friction integrator
package bvfi_pkg;

   localparam int AXES       = 3;
   localparam int AXIS_W     = 2;
   localparam int SQRT_ITERS = 32;
   localparam int QUO_W      = 25;
   localparam int ITER_W     = 5;
   localparam int CSR_ADDR_W = 3;

   localparam logic [63:0] SQRT_BIT0       = 64'h4000_0000_0000_0000;
   localparam logic [23:0] FRICTION_RESET  = 24'd0;
   localparam logic [23:0] MAX_SPEED_RESET = 24'd327680;

   localparam logic [1:0] OPC_STEP  = 2'd0;
   localparam logic [1:0] OPC_SET   = 2'd1;
   localparam logic [1:0] OPC_RESET = 2'd2;

   localparam logic REG_FRICTION  = 1'b0;
   localparam logic REG_MAX_SPEED = 1'b1;

   typedef logic signed [31:0] q16_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_FDT, ST_ADT, ST_FRIC, ST_SQ, ST_LIM, ST_CHK, ST_SQRT,
      ST_DMUL, ST_DIV, ST_DWB, ST_INTV, ST_INTP, ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      DP_NONE, DP_LOAD, DP_SET, DP_CLEAR, DP_FDT, DP_ADT, DP_FRIC, DP_SQ,
      DP_LIM, DP_SQRT, DP_DMUL, DP_DIV, DP_DWB, DP_INTV, DP_INTP, DP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type         op;
      logic [AXIS_W-1:0] axis;
   } cmd_type;

   typedef struct packed {
      logic over_limit;
   } status_type;

endpackage

@@ rtl/core/bvfi_req_if.sv @@
// request channel: opcode, time delta and acceleration word
interface bvfi_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         opcode;
   logic [15:0]        dt;
   logic signed [31:0] acc_x;
   logic signed [31:0] acc_y;
   logic signed [31:0] acc_z;

   modport source (output valid, opcode, dt, acc_x, acc_y, acc_z, input ready);
   modport sink   (input valid, opcode, dt, acc_x, acc_y, acc_z, output ready);
endinterface

@@ rtl/core/bvfi_rsp_if.sv @@
// response channel: position and velocity word
interface bvfi_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic signed [31:0] vel_x;
   logic signed [31:0] vel_y;
   logic signed [31:0] vel_z;

   modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, output ready);
endinterface

@@ rtl/core/bvfi_ctrl.sv @@
// sequencer that steps the datapath through one word
module bvfi_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_opcode,
   output logic                 req_ready,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   input  bvfi_pkg::status_type status,
   output bvfi_pkg::cmd_type    cmd
);
   import bvfi_pkg::*;

   state_type           state_ff, state_in;
   logic [AXIS_W-1:0]   axis_ff, axis_in;
   logic [ITER_W-1:0]   iter_ff, iter_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= '0;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      iter_in      = iter_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd.op       = DP_NONE;
      cmd.axis     = axis_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            axis_in   = '0;
            if (req_valid) begin
               case (req_opcode)
                  OPC_STEP: begin
                     cmd.op   = DP_LOAD;
                     state_in = ST_FDT;
                  end
                  OPC_SET: begin
                     cmd.op   = DP_SET;
                     state_in = ST_DONE;
                  end
                  OPC_RESET: begin
                     cmd.op   = DP_CLEAR;
                     state_in = ST_DONE;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_FDT: begin
            cmd.op   = DP_FDT;
            state_in = ST_ADT;
         end
         ST_ADT: begin
            cmd.op = DP_ADT;
            if (axis_ff == AXIS_W'(AXES - 1)) begin
               axis_in  = '0;
               state_in = ST_FRIC;
            end else begin
               axis_in = axis_ff + 1'b1;
            end
         end
         ST_FRIC: begin
            cmd.op   = DP_FRIC;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            cmd.op = DP_SQ;
            if (axis_ff == AXIS_W'(AXES - 1)) begin
               axis_in  = '0;
               state_in = ST_LIM;
            end else begin
               axis_in = axis_ff + 1'b1;
            end
         end
         ST_LIM: begin
            cmd.op   = DP_LIM;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            iter_in  = '0;
            state_in = status.over_limit ? ST_SQRT : ST_INTV;
         end
         ST_SQRT: begin
            cmd.op  = DP_SQRT;
            iter_in = iter_ff + 1'b1;
            if (iter_ff == ITER_W'(SQRT_ITERS - 1)) begin
               state_in = ST_DMUL;
            end
         end
         ST_DMUL: begin
            cmd.op   = DP_DMUL;
            iter_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.op  = DP_DIV;
            iter_in = iter_ff + 1'b1;
            if (iter_ff == ITER_W'(QUO_W - 1)) begin
               state_in = ST_DWB;
            end
         end
         ST_DWB: begin
            cmd.op = DP_DWB;
            if (axis_ff == AXIS_W'(AXES - 1)) begin
               axis_in  = '0;
               state_in = ST_INTV;
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = ST_DMUL;
            end
         end
         ST_INTV: begin
            cmd.op   = DP_INTV;
            state_in = ST_INTP;
         end
         ST_INTP: begin
            cmd.op   = DP_INTP;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = DP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/core/bvfi_dp.sv @@
// motion state, shared multiplier, square root and divide datapath
module bvfi_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  bvfi_pkg::cmd_type    cmd,
   output bvfi_pkg::status_type status,
   input  logic [15:0]          in_dt,
   input  bvfi_pkg::q16_type    in_acc [bvfi_pkg::AXES],
   input  logic [23:0]          friction,
   input  logic [23:0]          max_speed,
   output bvfi_pkg::q16_type    out_pos [bvfi_pkg::AXES],
   output bvfi_pkg::q16_type    out_vel [bvfi_pkg::AXES]
);
   import bvfi_pkg::*;

   q16_type            acc_ff [AXES];
   q16_type            vel_ff [AXES];
   q16_type            pos_ff [AXES];
   q16_type            adt_ff [AXES];
   q16_type            opos_ff [AXES];
   q16_type            ovel_ff [AXES];
   logic [15:0]        dt_ff;
   logic [23:0]        fdt_ff;
   logic [63:0]        sum_ff;
   logic               over_ff;
   logic [63:0]        rem_ff, res_ff, bit_ff;
   logic [32:0]        drem_ff;
   logic [QUO_W-1:0]   dnum_ff;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p;
   logic [31:0]        mag_sel;
   logic [63:0]        sq_trial;
   logic [32:0]        len;
   logic [33:0]        div_shift, div_diff;
   logic               div_ge;

   function automatic q16_type sat32(input logic signed [32:0] x);
      if (x > 33'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (x < -33'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return x[31:0];
   endfunction

   function automatic logic [31:0] mag32(input q16_type x);
      return x[31] ? (~x + 32'd1) : x;
   endfunction

   assign mag_sel = mag32(vel_ff[cmd.axis]);

   // one shared multiplier, result lands in a register of the current step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         DP_FDT: begin
            mul_a = {9'b0, friction};
            mul_b = {17'b0, dt_ff};
         end
         DP_ADT: begin
            mul_a = {acc_ff[cmd.axis][31], acc_ff[cmd.axis]};
            mul_b = {17'b0, dt_ff};
         end
         DP_SQ: begin
            mul_a = {1'b0, mag_sel};
            mul_b = {1'b0, mag_sel};
         end
         DP_LIM: begin
            mul_a = {9'b0, max_speed};
            mul_b = {9'b0, max_speed};
         end
         DP_DMUL: begin
            mul_a = {1'b0, mag_sel};
            mul_b = {9'b0, max_speed};
         end
         default: ;
      endcase
      mul_p = mul_a * mul_b;
   end

   assign sq_trial  = res_ff + bit_ff;
   assign len       = res_ff[32:0];
   assign div_shift = {drem_ff, dnum_ff[QUO_W-1]};
   assign div_diff  = div_shift - {1'b0, len};
   assign div_ge    = div_shift >= {1'b0, len};

   // motion state
   always_ff @(posedge clock) begin
      logic signed [32:0] probe;
      logic [32:0]        pmag;
      logic               any_nz;
      q16_type            q;
      if (reset) begin
         for (int i = 0; i < AXES; i++) begin
            acc_ff[i] <= '0;
            vel_ff[i] <= '0;
            pos_ff[i] <= '0;
         end
      end else begin
         any_nz = (vel_ff[0] != 0) || (vel_ff[1] != 0) || (vel_ff[2] != 0);
         case (cmd.op)
            DP_SET: begin
               for (int i = 0; i < AXES; i++) acc_ff[i] <= in_acc[i];
            end
            DP_CLEAR: begin
               for (int i = 0; i < AXES; i++) begin
                  acc_ff[i] <= '0;
                  vel_ff[i] <= '0;
                  pos_ff[i] <= '0;
               end
            end
            DP_FRIC: begin
               if (any_nz) begin
                  for (int i = 0; i < AXES; i++) begin
                     probe = {vel_ff[i][31], vel_ff[i]} + {adt_ff[i][31], adt_ff[i]};
                     pmag  = probe[32] ? (~probe + 33'd1) : probe;
                     if (pmag < {9'b0, fdt_ff}) begin
                        vel_ff[i] <= '0;
                        acc_ff[i] <= '0;
                     end else if (vel_ff[i] > 0) begin
                        vel_ff[i] <= sat32({vel_ff[i][31], vel_ff[i]} - {9'b0, fdt_ff});
                     end else if (vel_ff[i] < 0) begin
                        vel_ff[i] <= sat32({vel_ff[i][31], vel_ff[i]} + {9'b0, fdt_ff});
                     end
                  end
               end
            end
            DP_DWB: begin
               q = {{(32-QUO_W){1'b0}}, dnum_ff};
               vel_ff[cmd.axis] <= vel_ff[cmd.axis][31] ? -q : q;
            end
            DP_INTV: begin
               for (int i = 0; i < AXES; i++) begin
                  vel_ff[i] <= sat32({vel_ff[i][31], vel_ff[i]} + {adt_ff[i][31], adt_ff[i]});
               end
            end
            DP_INTP: begin
               for (int i = 0; i < AXES; i++) begin
                  pos_ff[i] <= sat32({pos_ff[i][31], pos_ff[i]} + {vel_ff[i][31], vel_ff[i]});
               end
            end
            default: ;
         endcase
      end
   end

   // working registers of one step
   always_ff @(posedge clock) begin
      logic signed [32:0] probe;
      logic [32:0]        pmag;
      case (cmd.op)
         DP_LOAD: dt_ff <= in_dt;
         DP_FDT:  fdt_ff <= mul_p[39:16];
         DP_ADT:  adt_ff[cmd.axis] <= mul_p[47:16];
         DP_FRIC: begin
            // a stopped axis drops its acceleration term too
            if ((vel_ff[0] != 0) || (vel_ff[1] != 0) || (vel_ff[2] != 0)) begin
               for (int i = 0; i < AXES; i++) begin
                  probe = {vel_ff[i][31], vel_ff[i]} + {adt_ff[i][31], adt_ff[i]};
                  pmag  = probe[32] ? (~probe + 33'd1) : probe;
                  if (pmag < {9'b0, fdt_ff}) adt_ff[i] <= '0;
               end
            end
         end
         DP_SQ: begin
            if (cmd.axis == '0) sum_ff <= mul_p[63:0];
            else sum_ff <= sum_ff + mul_p[63:0];
         end
         DP_LIM: begin
            over_ff <= sum_ff > mul_p[63:0];
            rem_ff  <= sum_ff;
            res_ff  <= '0;
            bit_ff  <= SQRT_BIT0;
         end
         DP_SQRT: begin
            if (rem_ff >= sq_trial) begin
               rem_ff <= rem_ff - sq_trial;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         DP_DMUL: begin
            // quotient never exceeds max_speed, so only the low bits iterate
            drem_ff <= mul_p[QUO_W+32:QUO_W];
            dnum_ff <= mul_p[QUO_W-1:0];
         end
         DP_DIV: begin
            drem_ff <= div_ge ? div_diff[32:0] : div_shift[32:0];
            dnum_ff <= {dnum_ff[QUO_W-2:0], div_ge};
         end
         DP_OUT: begin
            for (int i = 0; i < AXES; i++) begin
               opos_ff[i] <= pos_ff[i];
               ovel_ff[i] <= vel_ff[i];
            end
         end
         default: ;
      endcase
   end

   assign status.over_limit = over_ff;
   assign out_pos = opos_ff;
   assign out_vel = ovel_ff;

endmodule

@@ rtl/core/body_velocity_friction_integrator.sv @@
// top level of the velocity and friction integrator
//
// Keeps acceleration, velocity and position in signed Q16.16 and returns one
// response word (position and velocity after the request) per request word.
// A step scales friction and acceleration by dt, applies friction and checks
// the squared speed against max_speed squared; when the speed clamp fires, a
// floor square root plus a restoring divide per axis rescale the velocity,
// all multiplies sharing one 33x33 multiplier. One word is in work at a time;
// the response sits in an output register, so the next request is taken while
// the last response still waits. friction and max_speed sit at byte addresses
// 0x0 and 0x4 of the APB port; the user must write them only while the block
// is idle, and the block itself does not enforce this.
module body_velocity_friction_integrator (
   input  logic                                clock,
   input  logic                                reset,
   bvfi_req_if.sink                            req_chan,
   bvfi_rsp_if.source                          rsp_chan,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [bvfi_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);
   import bvfi_pkg::*;

   logic [23:0] friction_ff, max_speed_ff;
   cmd_type     cmd;
   status_type  status;
   q16_type     in_acc [AXES];
   q16_type     out_pos [AXES];
   q16_type     out_vel [AXES];

   // register file, write lands in the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         friction_ff  <= FRICTION_RESET;
         max_speed_ff <= MAX_SPEED_RESET;
      end else if (psel && penable && pwrite) begin
         case (paddr[2])
            REG_FRICTION:  friction_ff  <= pwdata[23:0];
            REG_MAX_SPEED: max_speed_ff <= pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_FRICTION: prdata = {8'b0, friction_ff};
         default:      prdata = {8'b0, max_speed_ff};
      endcase
   end

   assign pready = 1'b1;

   assign in_acc[0] = req_chan.acc_x;
   assign in_acc[1] = req_chan.acc_y;
   assign in_acc[2] = req_chan.acc_z;

   // sequencer
   bvfi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_opcode (req_chan.opcode),
      .req_ready  (req_chan.ready),
      .rsp_ready  (rsp_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .status     (status),
      .cmd        (cmd)
   );

   // motion state and arithmetic
   bvfi_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .in_dt     (req_chan.dt),
      .in_acc    (in_acc),
      .friction  (friction_ff),
      .max_speed (max_speed_ff),
      .out_pos   (out_pos),
      .out_vel   (out_vel)
   );

   // response word from the output register
   assign rsp_chan.pos_x = out_pos[0];
   assign rsp_chan.pos_y = out_pos[1];
   assign rsp_chan.pos_z = out_pos[2];
   assign rsp_chan.vel_x = out_vel[0];
   assign rsp_chan.vel_y = out_vel[1];
   assign rsp_chan.vel_z = out_vel[2];

endmodule
